// ===== sv/rdq_pkg.sv =====
// ---------------------------------------------------------------------------
// rdq_pkg: shared types and constants of the reversible deque
// Operation codes, controller states, field widths, parameter defaults and
// the command group that the controller sends to the datapath.
// ---------------------------------------------------------------------------
package rdq_pkg;

  localparam int unsigned DepthDefault     = 1024;
  localparam int unsigned DataWidthDefault = 32;

  localparam int unsigned OpWidth   = 2;
  localparam int unsigned ValueWidth = 32;
  localparam int unsigned PosWidth  = 10;
  localparam int unsigned DataOutWidth = 32;
  localparam int unsigned OccWidth  = 11;

  typedef enum logic [OpWidth-1:0] {
    OP_PUSH    = 2'd0,
    OP_POP     = 2'd1,
    OP_REVERSE = 2'd2,
    OP_READ    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic capture;   // latch the accepted input beat
    logic execute;   // access the store and update the pointers
    logic load_out;  // move the result into the output register
  } cmd_t;

endpackage

// ===== sv/rdq_ctrl.sv =====
// ---------------------------------------------------------------------------
// rdq_ctrl: sequencing controller of the reversible deque
// Walks each item through capture, store access and result hand-off, and
// owns the valid flag of the output register.
// ---------------------------------------------------------------------------
module rdq_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output rdq_pkg::cmd_t cmd_o
);
  import rdq_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_EXEC;
      end
      ST_EXEC: state_d = ST_FIN;
      ST_FIN: begin
        if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ST_EXEC: cmd_o.execute = 1'b1;
      ST_FIN:  cmd_o.load_out = !out_valid_q || out_ready_i;
      default: cmd_o = '0;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== sv/rdq_datapath.sv =====
// ---------------------------------------------------------------------------
// rdq_datapath: ring store, pointers and result registers of the deque
// Holds the element memory, the first pointer, the element count and the
// direction flag, and forms the result of each operation.
// ---------------------------------------------------------------------------
module rdq_datapath #(
  parameter int unsigned DEPTH      = rdq_pkg::DepthDefault,
  parameter int unsigned DATA_WIDTH = rdq_pkg::DataWidthDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rdq_pkg::cmd_t                     cmd_i,
  input  logic [rdq_pkg::OpWidth-1:0]       operation_i,
  input  logic [rdq_pkg::ValueWidth-1:0]    value_i,
  input  logic [rdq_pkg::PosWidth-1:0]      position_i,
  output logic [rdq_pkg::DataOutWidth-1:0]  data_o,
  output logic                              error_o,
  output logic [rdq_pkg::OccWidth-1:0]      occupancy_o,
  output logic                              reversed_o
);
  import rdq_pkg::*;

  localparam int unsigned PtrW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam int unsigned CmpW = (CntW > PosWidth) ? CntW : PosWidth;
  localparam logic [PtrW:0]   DepthX  = (PtrW + 1)'(DEPTH);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

  // Captured item.
  op_e                 op_q;
  logic [63:0]         val_q;
  logic [PosWidth-1:0] pos_q;

  // Deque state.
  logic [PtrW-1:0] first_q, first_d;
  logic [CntW-1:0] count_q, count_d;
  logic            dir_q, dir_d;

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;
  logic                  err_q, err_d;

  logic [DataOutWidth-1:0] out_data_q;
  logic                    out_err_q;
  logic [OccWidth-1:0]     out_occ_q;
  logic                    out_rev_q;

  logic [CntW-1:0] count_m1;
  logic            empty, full, read_oob;
  logic [PtrW-1:0] offset, slot, first_m1, first_p1, addr;
  logic [PtrW:0]   slot_sum;
  logic            wr_en;
  logic [63:0]     rdata_ext;

  assign count_m1 = count_q - 1'b1;
  assign empty    = (count_q == '0);
  assign full     = (count_q == CntFull);
  assign read_oob = (CmpW'(pos_q) >= CmpW'(count_q));
  assign first_m1 = (first_q == '0) ? LastIdx : first_q - 1'b1;
  assign first_p1 = (first_q == LastIdx) ? '0 : first_q + 1'b1;

  // Offset from the first pointer; always below DEPTH when it is used.
  always_comb begin
    offset = '0;
    case (op_q)
      OP_PUSH: offset = PtrW'(count_q);
      OP_POP:  offset = PtrW'(count_m1);
      OP_READ: offset = dir_q ? PtrW'(count_m1 - CntW'(pos_q)) : PtrW'(pos_q);
      default: offset = '0;
    endcase
  end

  assign slot_sum = {1'b0, first_q} + {1'b0, offset};
  assign slot     = (slot_sum >= DepthX) ? PtrW'(slot_sum - DepthX) : slot_sum[PtrW-1:0];

  always_comb begin
    addr = slot;
    if (op_q == OP_PUSH && dir_q) addr = first_m1;
    else if (op_q == OP_POP && !dir_q) addr = first_q;
  end

  always_comb begin
    first_d = first_q;
    count_d = count_q;
    dir_d   = dir_q;
    err_d   = 1'b0;
    wr_en   = 1'b0;
    case (op_q)
      OP_PUSH: begin
        if (full) begin
          err_d = 1'b1;
        end else begin
          wr_en   = 1'b1;
          count_d = count_q + 1'b1;
          if (dir_q) first_d = first_m1;
        end
      end
      OP_POP: begin
        if (empty) begin
          err_d = 1'b1;
        end else begin
          count_d = count_m1;
          if (!dir_q) first_d = first_p1;
        end
      end
      OP_REVERSE: dir_d = ~dir_q;
      OP_READ:    err_d = read_oob;
      default:    err_d = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      op_q  <= op_e'(operation_i);
      val_q <= 64'(value_i);
      pos_q <= position_i;
    end
    if (cmd_i.execute) err_q <= err_d;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.execute && wr_en) mem[addr] <= val_q[DATA_WIDTH-1:0];
    if (cmd_i.execute) rdata_q <= mem[addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_q <= '0;
      count_q <= '0;
      dir_q   <= 1'b0;
    end else if (cmd_i.execute) begin
      first_q <= first_d;
      count_q <= count_d;
      dir_q   <= dir_d;
    end
  end

  assign rdata_ext = 64'(rdata_q);

  // Only a successful pop or read returns store data.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_data_q <= ((op_q == OP_POP || op_q == OP_READ) && !err_q) ?
                    rdata_ext[DataOutWidth-1:0] : '0;
      out_err_q  <= err_q;
      out_occ_q  <= OccWidth'(count_q);
      out_rev_q  <= dir_q;
    end
  end

  assign data_o      = out_data_q;
  assign error_o     = out_err_q;
  assign occupancy_o = out_occ_q;
  assign reversed_o  = out_rev_q;

endmodule

// ===== sv/reversible_deque_unit.sv =====
// ---------------------------------------------------------------------------
// reversible_deque_unit: bounded double-ended queue with a direction flag
// Push at the logical back, pop at the logical front, flip direction, or
// read at a logical position; one result beat per input beat.
// ---------------------------------------------------------------------------
// Each input beat goes through the controller states IDLE, EXEC and FIN. The
// accepting edge in IDLE captures the item, the EXEC step accesses the ring
// memory and updates the pointers, and the FIN step moves the registered
// memory read into the output register. The block takes no new item until
// FIN has loaded the result of the current one. FIN waits while the output
// register still holds a result that has not been taken.
// No clearing pass is needed after reset; store data are only returned from
// slots that a push has written.
module reversible_deque_unit #(
  parameter int unsigned DEPTH      = rdq_pkg::DepthDefault,
  parameter int unsigned DATA_WIDTH = rdq_pkg::DataWidthDefault
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [rdq_pkg::OpWidth-1:0]      operation_i,
  input  logic [rdq_pkg::ValueWidth-1:0]   value_i,
  input  logic [rdq_pkg::PosWidth-1:0]     position_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [rdq_pkg::DataOutWidth-1:0] data_o,
  output logic                             error_o,
  output logic [rdq_pkg::OccWidth-1:0]     occupancy_o,
  output logic                             reversed_o
);
  import rdq_pkg::*;

  cmd_t cmd;

  rdq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  rdq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .operation_i (operation_i),
    .value_i     (value_i),
    .position_i  (position_i),
    .data_o      (data_o),
    .error_o     (error_o),
    .occupancy_o (occupancy_o),
    .reversed_o  (reversed_o)
  );

endmodule

// ===== sv/rdq_checker.sv =====
// ---------------------------------------------------------------------------
// rdq_checker: port-level checks for the reversible deque
// Watches the top-level ports and flags broken handshakes or results that
// the deque can never produce.
// ---------------------------------------------------------------------------
module rdq_checker #(
  parameter int unsigned DEPTH = rdq_pkg::DepthDefault
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_o,
  input logic                             out_valid_o,
  input logic                             out_ready_i,
  input logic [rdq_pkg::DataOutWidth-1:0] data_o,
  input logic                             error_o,
  input logic [rdq_pkg::OccWidth-1:0]     occupancy_o,
  input logic                             reversed_o
);
  import rdq_pkg::*;

  localparam bit OccFits = (DEPTH < (1 << OccWidth));
  localparam logic [OccWidth:0] DepthX = (OccWidth + 1)'(DEPTH);

  // A result beat that is stalled stays offered.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // A stalled result keeps its data.
  a_data_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(data_o))
    else $error("result data changed while stalled");

  // The block works on one item at a time.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second item accepted while one is in flight");

  // A failed operation never returns data.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> (data_o == '0))
    else $error("error result carries data");

  // The count never exceeds the store depth.
  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !OccFits || ({1'b0, occupancy_o} <= DepthX))
    else $error("occupancy beyond depth");

endmodule

bind reversible_deque_unit rdq_checker #(.DEPTH(DEPTH)) u_rdq_checker (.*);
